@@ design/alt_pkg.sv @@
// Package for the allocation leak tracker: constants, codes and record type.
`timescale 1ns / 1ps
package alt_pkg;
	localparam int unsigned TableEntries = 4096;
	localparam int unsigned IdxW = $clog2(TableEntries);
	localparam int unsigned CntW = IdxW + 1;
	localparam int unsigned AddrW = 48;
	localparam int unsigned WordW = 32;
	localparam int unsigned RecW = AddrW + 3 * WordW + 1;
	localparam logic [WordW-1:0] DefaultThreshold = 32'd1024;
	localparam logic [AddrW-1:0] UsageMax = {AddrW{1'b1}};

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE = 2'd1;
	localparam logic [1:0] FUNC_SCAN = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_TRACKING = 1'b1;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [WordW-1:0] size;
		logic [WordW-1:0] site;
		logic [WordW-1:0] stamp;
		logic freed;
	} rec_t;
endpackage

@@ design/alt_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module alt_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ design/allocation_leak_tracker_unit.sv @@
// Top level of the allocation leak tracker: sequencer around the record table.
//
// Usage: an item enters on in_valid/in_stall-free handshake (in_stall is driven
// by this block), its one result leaves on out_valid while out_stall is low.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is the scan threshold, index 1 is tracking_on, others are ignored.
// One item is worked at a time. Alloc, clear and rejected items go straight to
// S_DONE and write their result from there; the next item is taken after that.
// A free or scan walks the record table one entry per cycle through the single
// RAM read port, from S_READ through S_CHECK, and stops at a match or at the
// fill count.
// The result sits in an output register; the next item is accepted while it
// waits for the receiver, and work on that item stops only when a new result
// must be written while the old one is still stalled.
// Reset clears the counters and the table fill count at once (no clearing
// pass); table entries at or above the fill count are never tested for a match.
// Registers reset to threshold 1024 and tracking on.
`timescale 1ns / 1ps
module allocation_leak_tracker_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic [47:0] block_addr,
	input logic [31:0] block_size,
	input logic [31:0] site_tag,
	input logic [31:0] time_stamp,
	input logic [11:0] start_index,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic leak_found,
	output logic [11:0] leak_index,
	output logic [47:0] leak_addr,
	output logic [31:0] leak_size,
	output logic [31:0] leak_site,
	output logic [31:0] leak_time,
	output logic [12:0] record_count,
	output logic [12:0] live_count,
	output logic [47:0] usage_now,
	output logic [47:0] usage_peak,
	output logic [47:0] bytes_allocated,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	localparam int unsigned IdxW = alt_pkg::IdxW;
	localparam int unsigned CntW = alt_pkg::CntW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;

	logic [2:0] state_q;
	logic [1:0] func_q;
	logic [47:0] addr_q;
	logic [31:0] size_q, site_q, stamp_q;
	logic [CntW-1:0] idx_q;
	logic [1:0] res_status_q;
	logic res_found_q;
	alt_pkg::rec_t res_rec_q;
	logic [IdxW-1:0] res_idx_q;

	logic [31:0] thresh_q;
	logic track_q;
	logic [CntW-1:0] fill_q, live_q;
	logic [47:0] cur_q, peak_q, total_q;

	logic ram_we;
	logic [IdxW-1:0] ram_addr;
	alt_pkg::rec_t ram_wdata, ram_rdata;

	logic accept;
	logic [31:0] thr;
	logic [48:0] add_cur, add_tot;
	logic [47:0] cur_next, tot_sat;
	logic hit;
	logic walk_end;
	logic done_alloc;
	logic [CntW-1:0] fill_upd, live_upd;
	logic [47:0] cur_upd, peak_upd, total_upd;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign thr = (thresh_q == '0) ? alt_pkg::DefaultThreshold : thresh_q;
	assign add_cur = {1'b0, cur_q} + {17'd0, size_q};
	assign add_tot = {1'b0, total_q} + {17'd0, size_q};
	assign cur_next = add_cur[48] ? alt_pkg::UsageMax : add_cur[47:0];
	assign tot_sat = add_tot[48] ? alt_pkg::UsageMax : add_tot[47:0];
	assign walk_end = (idx_q >= fill_q);
	assign done_alloc = (func_q == alt_pkg::FUNC_ALLOC) && (res_status_q == alt_pkg::ST_OK);

	// match test on the entry read in the previous cycle
	always_comb begin
		if (func_q == alt_pkg::FUNC_FREE) begin
			hit = (ram_rdata.addr == addr_q) && !ram_rdata.freed;
		end else begin
			hit = !ram_rdata.freed && (ram_rdata.size >= thr);
		end
	end

	// counter values once the finished item is retired
	always_comb begin
		fill_upd = fill_q;
		live_upd = live_q;
		cur_upd = cur_q;
		peak_upd = peak_q;
		total_upd = total_q;
		if (done_alloc) begin
			fill_upd = fill_q + 1'b1;
			live_upd = live_q + 1'b1;
			cur_upd = cur_next;
			total_upd = tot_sat;
			if (cur_next > peak_q) begin
				peak_upd = cur_next;
			end
		end else if (func_q == alt_pkg::FUNC_CLEAR) begin
			fill_upd = '0;
			live_upd = '0;
			cur_upd = '0;
			peak_upd = '0;
			total_upd = '0;
		end
	end

	// RAM port: write on alloc or free hit, read for the walk
	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q[IdxW-1:0];
		ram_wdata = ram_rdata;
		if (state_q == S_CHECK && hit && func_q == alt_pkg::FUNC_FREE) begin
			ram_we = 1'b1;
			ram_addr = res_idx_q;
			ram_wdata.freed = 1'b1;
		end else if (state_q == S_DONE && done_alloc) begin
			ram_we = 1'b1;
			ram_addr = fill_q[IdxW-1:0];
			ram_wdata = '{addr: addr_q, size: size_q, site: site_q,
				stamp: stamp_q, freed: 1'b0};
		end
	end

	alt_ram #(.Width(alt_pkg::RecW), .Depth(alt_pkg::TableEntries)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			thresh_q <= alt_pkg::DefaultThreshold;
			track_q <= 1'b1;
			fill_q <= '0;
			live_q <= '0;
			cur_q <= '0;
			peak_q <= '0;
			total_q <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					alt_pkg::CFG_THRESHOLD: thresh_q <= cfg_data;
					alt_pkg::CFG_TRACKING: track_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func;
						addr_q <= block_addr;
						size_q <= block_size;
						site_q <= site_tag;
						stamp_q <= time_stamp;
						res_found_q <= 1'b0;
						case (func)
							alt_pkg::FUNC_ALLOC: begin
								state_q <= S_DONE;
								res_status_q <= (block_addr == '0 || !track_q ||
										fill_q >= CntW'(alt_pkg::TableEntries)) ?
									alt_pkg::ST_REJECT : alt_pkg::ST_OK;
							end
							alt_pkg::FUNC_FREE: begin
								idx_q <= '0;
								if (block_addr == '0 || !track_q) begin
									res_status_q <= alt_pkg::ST_REJECT;
									state_q <= S_DONE;
								end else begin
									res_status_q <= alt_pkg::ST_NOT_FOUND;
									state_q <= S_READ;
								end
							end
							alt_pkg::FUNC_SCAN: begin
								idx_q <= {1'b0, start_index};
								res_status_q <= alt_pkg::ST_OK;
								state_q <= S_READ;
							end
							default: begin
								res_status_q <= alt_pkg::ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					if (walk_end) begin
						state_q <= S_DONE;
					end else begin
						res_idx_q <= idx_q[IdxW-1:0];
						idx_q <= idx_q + 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (hit) begin
						res_rec_q <= ram_rdata;
						state_q <= S_DONE;
						if (func_q == alt_pkg::FUNC_FREE) begin
							res_status_q <= alt_pkg::ST_OK;
							live_q <= live_q - 1'b1;
							cur_q <= (cur_q >= {16'd0, ram_rdata.size}) ?
								cur_q - {16'd0, ram_rdata.size} : '0;
						end else begin
							res_found_q <= 1'b1;
						end
					end else if (walk_end) begin
						state_q <= S_DONE;
					end else begin
						res_idx_q <= idx_q[IdxW-1:0];
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						state_q <= S_IDLE;
						out_valid <= 1'b1;
						status <= res_status_q;
						leak_found <= res_found_q;
						leak_index <= res_found_q ? res_idx_q : '0;
						leak_addr <= res_found_q ? res_rec_q.addr : '0;
						leak_size <= res_found_q ? res_rec_q.size : '0;
						leak_site <= res_found_q ? res_rec_q.site : '0;
						leak_time <= res_found_q ? res_rec_q.stamp : '0;
						fill_q <= fill_upd;
						live_q <= live_upd;
						cur_q <= cur_upd;
						peak_q <= peak_upd;
						total_q <= total_upd;
						record_count <= fill_upd;
						live_count <= live_upd;
						usage_now <= cur_upd;
						usage_peak <= peak_upd;
						bytes_allocated <= total_upd;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_live_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= fill_q) else $error("live count above record count");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(alt_pkg::TableEntries)) else $error("fill count overflow");
	a_peak_ge_cur: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= cur_q) else $error("peak below current usage");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept) else $error("item accepted while busy");
`endif
endmodule
